// ===== src/ggcr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ggcr_pkg
// Shared constants and types for the grain growth cell rule: register
// indexes, rule thresholds and the per-lane summary passed to the merge stage.
// ----------------------------------------------------------------------------
package ggcr_pkg;

  localparam int ID_WIDTH_DEF       = 16;
  localparam int EXCLUDED_SLOTS_DEF = 4;

  // Excluded id slots that the register map provides
  localparam int CFG_SLOTS = 4;

  localparam int PROB_W  = 7;
  localparam int INDEX_W = 3;

  // Neighbour counts: one side (four cells) and the whole Moore ring
  localparam int QCNT_W = 3;
  localparam int MCNT_W = 4;

  localparam logic [INDEX_W-1:0] REG_MODE   = 3'd0;
  localparam logic [INDEX_W-1:0] REG_PROB   = 3'd1;
  localparam logic [INDEX_W-1:0] REG_EXCL_A = 3'd2;

  localparam logic [MCNT_W-1:0] MOORE_MIN  = 4'd5;
  localparam logic [MCNT_W-1:0] SIDE_EXACT = 4'd3;

  localparam logic MODE_SIMPLE = 1'b0;

  typedef struct packed {
    logic              valid;      // neither empty nor inclusion
    logic              excl;       // matches an active excluded slot
    logic [QCNT_W-1:0] side_cnt;   // occurrences among edge neighbours
    logic [QCNT_W-1:0] corner_cnt; // occurrences among diagonal neighbours
  } lane_info_t;

endpackage
`default_nettype wire

// ===== src/ggcr_lane.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ggcr_lane
// One neighbour lane: counts how often this neighbour's id occurs among the
// edge and diagonal neighbours and flags empty, inclusion and excluded ids.
// ----------------------------------------------------------------------------
module ggcr_lane #(
  parameter int ID_WIDTH  = ggcr_pkg::ID_WIDTH_DEF,
  parameter int EXCL_USED = ggcr_pkg::CFG_SLOTS
) (
  input  wire                                    clk,
  input  wire  [ID_WIDTH-1:0]                    nbr_id,
  input  wire  [3:0][ID_WIDTH-1:0]               side_ids,
  input  wire  [3:0][ID_WIDTH-1:0]               corner_ids,
  input  wire  [EXCL_USED-1:0][ID_WIDTH-2:0]     excl_ids,
  output logic [ID_WIDTH-1:0]                    lane_id,
  output ggcr_pkg::lane_info_t                   lane_info
);

  ggcr_pkg::lane_info_t info_next;

  always_comb begin
    info_next.side_cnt   = '0;
    info_next.corner_cnt = '0;
    for (int j = 0; j < 4; j++) begin
      info_next.side_cnt   = info_next.side_cnt +
                             ggcr_pkg::QCNT_W'(side_ids[j] == nbr_id);
      info_next.corner_cnt = info_next.corner_cnt +
                             ggcr_pkg::QCNT_W'(corner_ids[j] == nbr_id);
    end
    info_next.valid = (nbr_id != '0) && (nbr_id != '1);
    // slots hold non-negative ids only, zero marks an unused slot
    info_next.excl = 1'b0;
    for (int k = 0; k < EXCL_USED; k++) begin
      if (excl_ids[k] != '0 && !nbr_id[ID_WIDTH-1] &&
          nbr_id[ID_WIDTH-2:0] == excl_ids[k]) begin
        info_next.excl = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    lane_id   <= nbr_id;
    lane_info <= info_next;
  end

endmodule
`default_nettype wire

// ===== src/ggcr_merge.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ggcr_merge
// Merge stage: picks the majority id of the edge, diagonal and Moore sets
// from the lane summaries, applies the growth rules and registers the result.
// ----------------------------------------------------------------------------
module ggcr_merge #(
  parameter int ID_WIDTH = ggcr_pkg::ID_WIDTH_DEF
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                in_valid,
  input  wire  [ID_WIDTH-1:0]                center_id,
  input  wire  [ggcr_pkg::PROB_W-1:0]        random_percent,
  input  wire                                growth_mode,
  input  wire  [ggcr_pkg::PROB_W-1:0]        growth_probability,
  input  wire  [7:0][ID_WIDTH-1:0]           lane_id,
  input  ggcr_pkg::lane_info_t [7:0]         lane_info,
  output logic                               done,
  output logic [ID_WIDTH-1:0]                new_id,
  output logic                               grew
);

  typedef struct packed {
    logic                        valid;
    logic                        excl;
    logic [ggcr_pkg::MCNT_W-1:0] cnt;
    logic [ID_WIDTH-1:0]         id;
  } cand_t;

  typedef cand_t [7:0] cand_set_t;

  // Higher count wins, a tie goes to the smaller signed id
  function automatic cand_t better(cand_t a, cand_t b);
    cand_t r;
    if (!b.valid) begin
      r = a;
    end else if (!a.valid) begin
      r = b;
    end else if (a.cnt > b.cnt ||
                 (a.cnt == b.cnt && $signed(a.id) < $signed(b.id))) begin
      r = a;
    end else begin
      r = b;
    end
    return r;
  endfunction

  function automatic cand_t pick(cand_set_t c);
    cand_t l1 [4];
    cand_t l2 [2];
    for (int i = 0; i < 4; i++) begin
      l1[i] = better(c[2*i], c[2*i+1]);
    end
    for (int i = 0; i < 2; i++) begin
      l2[i] = better(l1[2*i], l1[2*i+1]);
    end
    return better(l2[0], l2[1]);
  endfunction

  cand_set_t simple_set, side_set, corner_set, moore_set;
  cand_t     simple_win, side_win, corner_win, moore_win;
  logic      rule_moore, rule_side, rule_corner, rule_draw;
  logic [ID_WIDTH-1:0] new_id_next;
  logic                grew_next;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      moore_set[i].valid = lane_info[i].valid;
      moore_set[i].excl  = lane_info[i].excl;
      moore_set[i].id    = lane_id[i];
      moore_set[i].cnt   = {1'b0, lane_info[i].side_cnt} +
                           {1'b0, lane_info[i].corner_cnt};

      side_set[i]       = moore_set[i];
      side_set[i].valid = lane_info[i].valid && (i < 4);
      side_set[i].cnt   = {1'b0, lane_info[i].side_cnt};

      simple_set[i]       = side_set[i];
      simple_set[i].valid = side_set[i].valid && !lane_info[i].excl;

      corner_set[i]       = moore_set[i];
      corner_set[i].valid = lane_info[i].valid && (i >= 4);
      corner_set[i].cnt   = {1'b0, lane_info[i].corner_cnt};
    end
    simple_win = pick(simple_set);
    side_win   = pick(side_set);
    corner_win = pick(corner_set);
    moore_win  = pick(moore_set);
  end

  // An excluded winner vetoes its rule; so does an invalid winner
  always_comb begin
    rule_moore  = moore_win.valid && !moore_win.excl &&
                  moore_win.cnt >= ggcr_pkg::MOORE_MIN;
    rule_side   = side_win.valid && !side_win.excl &&
                  side_win.cnt == ggcr_pkg::SIDE_EXACT;
    rule_corner = corner_win.valid && !corner_win.excl &&
                  corner_win.cnt == ggcr_pkg::SIDE_EXACT;
    rule_draw   = moore_win.valid && !moore_win.excl &&
                  random_percent < growth_probability;

    new_id_next = center_id;
    grew_next   = 1'b0;
    if (center_id == '0) begin
      if (growth_mode == ggcr_pkg::MODE_SIMPLE) begin
        if (simple_win.valid) begin
          new_id_next = simple_win.id;
          grew_next   = 1'b1;
        end
      end else if (rule_moore) begin
        new_id_next = moore_win.id;
        grew_next   = 1'b1;
      end else if (rule_side) begin
        new_id_next = side_win.id;
        grew_next   = 1'b1;
      end else if (rule_corner) begin
        new_id_next = corner_win.id;
        grew_next   = 1'b1;
      end else if (rule_draw) begin
        new_id_next = moore_win.id;
        grew_next   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
    new_id <= new_id_next;
    grew   <= grew_next;
  end

endmodule
`default_nettype wire

// ===== src/grain_growth_cell_rule.sv =====
`default_nettype none
// Pipeline: a transaction accepted on start is registered in the neighbour lanes,
//   then in the merge stage, which raises done with its result.
// Throughput: one transaction per cycle; busy stays low, the receiver cannot stall.
// Reset: clears all configuration registers to zero and drops the result strobe;
//   transactions in flight at reset are lost.
// ----------------------------------------------------------------------------
// grain_growth_cell_rule
// Next grain id of one cell from its eight neighbours: eight counting lanes
// and a merge stage that applies simple or curvature-driven growth rules.
// ----------------------------------------------------------------------------
module grain_growth_cell_rule #(
  parameter int ID_WIDTH       = ggcr_pkg::ID_WIDTH_DEF,
  parameter int EXCLUDED_SLOTS = ggcr_pkg::EXCLUDED_SLOTS_DEF
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                start,
  output logic                               busy,
  input  wire                                wr_en,
  input  wire  [ggcr_pkg::INDEX_W-1:0]       wr_index,
  input  wire  [((ID_WIDTH-1 > ggcr_pkg::PROB_W) ? ID_WIDTH-1 : ggcr_pkg::PROB_W)-1:0]
                                             wr_data,
  input  wire  [ID_WIDTH-1:0]                center_id,
  input  wire  [ID_WIDTH-1:0]                north_id,
  input  wire  [ID_WIDTH-1:0]                east_id,
  input  wire  [ID_WIDTH-1:0]                south_id,
  input  wire  [ID_WIDTH-1:0]                west_id,
  input  wire  [ID_WIDTH-1:0]                northeast_id,
  input  wire  [ID_WIDTH-1:0]                southeast_id,
  input  wire  [ID_WIDTH-1:0]                southwest_id,
  input  wire  [ID_WIDTH-1:0]                northwest_id,
  input  wire  [ggcr_pkg::PROB_W-1:0]        random_percent,
  output logic                               done,
  output logic [ID_WIDTH-1:0]                new_id,
  output logic                               grew
);

  localparam int EXCL_USED = (EXCLUDED_SLOTS < ggcr_pkg::CFG_SLOTS) ?
                             EXCLUDED_SLOTS : ggcr_pkg::CFG_SLOTS;

  logic                                growth_mode;
  logic [ggcr_pkg::PROB_W-1:0]         growth_probability;
  logic [EXCL_USED-1:0][ID_WIDTH-2:0]  excl_ids;

  logic                                valid1;
  logic [ID_WIDTH-1:0]                 center_q;
  logic [ggcr_pkg::PROB_W-1:0]         rnd_q;

  logic [3:0][ID_WIDTH-1:0]            side_ids, corner_ids;
  logic [7:0][ID_WIDTH-1:0]            nbr_ids;
  logic [7:0][ID_WIDTH-1:0]            lane_id;
  ggcr_pkg::lane_info_t [7:0]          lane_info;
  logic                                accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign side_ids   = {west_id, south_id, east_id, north_id};
  assign corner_ids = {northwest_id, southwest_id, southeast_id, northeast_id};
  assign nbr_ids    = {corner_ids, side_ids};

  // Configuration registers; writes to unused indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      growth_mode        <= 1'b0;
      growth_probability <= '0;
      excl_ids           <= '0;
    end else if (wr_en) begin
      if (wr_index == ggcr_pkg::REG_MODE) begin
        growth_mode <= wr_data[0];
      end
      if (wr_index == ggcr_pkg::REG_PROB) begin
        growth_probability <= wr_data[ggcr_pkg::PROB_W-1:0];
      end
      for (int k = 0; k < EXCL_USED; k++) begin
        if (wr_index == ggcr_pkg::REG_EXCL_A + ggcr_pkg::INDEX_W'(k)) begin
          excl_ids[k] <= wr_data[ID_WIDTH-2:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else begin
      valid1 <= accept;
    end
    center_q <= center_id;
    rnd_q    <= random_percent;
  end

  for (genvar i = 0; i < 8; i++) begin : g_lane
    ggcr_lane #(
      .ID_WIDTH  (ID_WIDTH),
      .EXCL_USED (EXCL_USED)
    ) u_lane (
      .clk        (clk),
      .nbr_id     (nbr_ids[i]),
      .side_ids   (side_ids),
      .corner_ids (corner_ids),
      .excl_ids   (excl_ids),
      .lane_id    (lane_id[i]),
      .lane_info  (lane_info[i])
    );
  end

  ggcr_merge #(
    .ID_WIDTH (ID_WIDTH)
  ) u_merge (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (valid1),
    .center_id          (center_q),
    .random_percent     (rnd_q),
    .growth_mode        (growth_mode),
    .growth_probability (growth_probability),
    .lane_id            (lane_id),
    .lane_info          (lane_info),
    .done               (done),
    .new_id             (new_id),
    .grew               (grew)
  );

`ifndef SYNTH
  a_done_follows_accept: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 2))
    else $error("result strobe without a transaction two cycles earlier");

  a_grew_from_empty: assert property (@(posedge clk) disable iff (rst)
    (done && grew) |-> ($past(center_id, 2) == '0))
    else $error("growth reported for an occupied cell");

  a_grew_valid_id: assert property (@(posedge clk) disable iff (rst)
    (done && grew) |-> (new_id != '0 && new_id != '1))
    else $error("grown cell took an empty or inclusion id");

  a_hold_center: assert property (@(posedge clk) disable iff (rst)
    (done && !grew) |-> (new_id == $past(center_id, 2)))
    else $error("cell changed without growth");
`endif

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for grain_growth_cell_rule. A clocked driver feeds cell
// neighbourhoods from a queue. Each accepted transaction is run through a
// local next-id predictor, and a clocked monitor compares every result strobe
// against the oldest prediction. Register settings change between phases,
// only once the block has drained.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int ID_W         = ggcr_pkg::ID_WIDTH_DEF;
  localparam int WR_W         = (ID_W-1 > ggcr_pkg::PROB_W) ? ID_W-1 : ggcr_pkg::PROB_W;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 6;

  localparam logic [ggcr_pkg::INDEX_W-1:0] REG_EXCL_B   = ggcr_pkg::REG_EXCL_A + 3'd1;
  localparam logic [ggcr_pkg::INDEX_W-1:0] REG_EXCL_C   = ggcr_pkg::REG_EXCL_A + 3'd2;
  localparam logic [ggcr_pkg::INDEX_W-1:0] REG_EXCL_D   = ggcr_pkg::REG_EXCL_A + 3'd3;
  localparam logic [ggcr_pkg::INDEX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [ggcr_pkg::INDEX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam logic MODE_CURVE = 1'b1;

  typedef logic signed [ID_W-1:0] id_t;

  localparam id_t ID_EMPTY     = '0;
  localparam id_t ID_INCLUSION = '1;
  localparam id_t ID_MAX       = {1'b0, {(ID_W-1){1'b1}}};
  localparam id_t ID_MIN       = {1'b1, {(ID_W-1){1'b0}}};

  typedef struct packed {
    id_t                         center;
    id_t                         north;
    id_t                         east;
    id_t                         south;
    id_t                         west;
    id_t                         northeast;
    id_t                         southeast;
    id_t                         southwest;
    id_t                         northwest;
    logic [ggcr_pkg::PROB_W-1:0] pct;
  } cell_item_t;

  typedef struct packed {
    id_t  new_id;
    logic grew;
  } cell_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                          start          = 1'b0;
  logic                          busy;
  logic                          wr_en          = 1'b0;
  logic [ggcr_pkg::INDEX_W-1:0]  wr_index       = '0;
  logic [WR_W-1:0]               wr_data        = '0;
  logic [ID_W-1:0]               center_id      = '0;
  logic [ID_W-1:0]               north_id       = '0;
  logic [ID_W-1:0]               east_id        = '0;
  logic [ID_W-1:0]               south_id       = '0;
  logic [ID_W-1:0]               west_id        = '0;
  logic [ID_W-1:0]               northeast_id   = '0;
  logic [ID_W-1:0]               southeast_id   = '0;
  logic [ID_W-1:0]               southwest_id   = '0;
  logic [ID_W-1:0]               northwest_id   = '0;
  logic [ggcr_pkg::PROB_W-1:0]   random_percent = '0;
  logic                          done;
  logic [ID_W-1:0]               new_id;
  logic                          grew;

  // local copy of the register file
  logic                        mode_r = ggcr_pkg::MODE_SIMPLE;
  logic [ggcr_pkg::PROB_W-1:0] prob_r = '0;
  logic [ID_W-2:0]             excl_r [ggcr_pkg::CFG_SLOTS];

  cell_item_t   cells_to_send [$];
  cell_result_t next_ids_due  [$];
  cell_item_t   cell_on_port;

  int idle_pct      = 0;
  int faults        = 0;
  int cells_sent    = 0;
  int cells_grown   = 0;
  int settings_seen = 0;
  int cycle_count   = 0;

  grain_growth_cell_rule dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .wr_en          (wr_en),
    .wr_index       (wr_index),
    .wr_data        (wr_data),
    .center_id      (center_id),
    .north_id       (north_id),
    .east_id        (east_id),
    .south_id       (south_id),
    .west_id        (west_id),
    .northeast_id   (northeast_id),
    .southeast_id   (southeast_id),
    .southwest_id   (southwest_id),
    .northwest_id   (northwest_id),
    .random_percent (random_percent),
    .done           (done),
    .new_id         (new_id),
    .grew           (grew)
  );

  always #2 clk = ~clk;

  initial begin
    for (int k = 0; k < ggcr_pkg::CFG_SLOTS; k++) excl_r[k] = '0;
  end

  function automatic bit is_barred(id_t g);
    for (int k = 0; k < ggcr_pkg::CFG_SLOTS; k++) begin
      if (excl_r[k] != '0 && g == $signed({1'b0, excl_r[k]})) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Most frequent countable id among ring[lo +: n]; a tie goes to the smaller id
  function automatic id_t dominant_grain(input id_t ring [8], input int lo, input int n,
                                         input bit skip_barred, output int hits);
    id_t best;
    int  c;
    best = ID_EMPTY;
    hits = 0;
    for (int i = lo; i < lo + n; i++) begin
      if (ring[i] == ID_EMPTY || ring[i] == ID_INCLUSION) continue;
      if (skip_barred && is_barred(ring[i])) continue;
      c = 0;
      for (int j = lo; j < lo + n; j++) if (ring[j] == ring[i]) c++;
      if (c > hits || (c == hits && ring[i] < best)) begin
        hits = c;
        best = ring[i];
      end
    end
    return best;
  endfunction

  function automatic cell_result_t next_grain_id(cell_item_t c);
    id_t          ring [8];
    id_t          w;
    int           hits;
    bit           took;
    cell_result_t r;
    ring[0] = c.north;     ring[1] = c.east;      ring[2] = c.south;     ring[3] = c.west;
    ring[4] = c.northeast; ring[5] = c.southeast; ring[6] = c.southwest; ring[7] = c.northwest;
    took = 1'b0;
    w    = ID_EMPTY;
    if (c.center == ID_EMPTY) begin
      if (mode_r == ggcr_pkg::MODE_SIMPLE) begin
        w    = dominant_grain(ring, 0, 4, 1'b1, hits);
        took = (w != ID_EMPTY);
      end else begin
        // curvature rules: first one that fires decides, a barred winner vetoes
        w    = dominant_grain(ring, 0, 8, 1'b0, hits);
        took = hits >= int'(ggcr_pkg::MOORE_MIN) && !is_barred(w);
        if (!took) begin
          w    = dominant_grain(ring, 0, 4, 1'b0, hits);
          took = hits == int'(ggcr_pkg::SIDE_EXACT) && !is_barred(w);
        end
        if (!took) begin
          w    = dominant_grain(ring, 4, 4, 1'b0, hits);
          took = hits == int'(ggcr_pkg::SIDE_EXACT) && !is_barred(w);
        end
        if (!took) begin
          w    = dominant_grain(ring, 0, 8, 1'b0, hits);
          took = w != ID_EMPTY && c.pct < prob_r && !is_barred(w);
        end
      end
    end
    r.new_id = took ? w : c.center;
    r.grew   = took;
    return r;
  endfunction

  function automatic cell_item_t neighbourhood(id_t ctr, id_t n, id_t e, id_t s, id_t w,
                                               id_t ne, id_t se, id_t sw, id_t nw,
                                               logic [ggcr_pkg::PROB_W-1:0] pct);
    cell_item_t c;
    c.center = ctr;  c.north = n;      c.east = e;       c.south = s;      c.west = w;
    c.northeast = ne; c.southeast = se; c.southwest = sw; c.northwest = nw; c.pct = pct;
    return c;
  endfunction

  // Append a transaction to the tail of the send queue
  function automatic void queue_cell(cell_item_t c);
    cells_to_send.insert(cells_to_send.size(), c);
  endfunction

  function automatic id_t pick_grain();
    int roll;
    roll = $urandom_range(99);
    if (roll < 40) return id_t'($urandom_range(6, 1));
    if (roll < 50) return $signed({1'b0, excl_r[$urandom_range(ggcr_pkg::CFG_SLOTS-1)]});
    if (roll < 60) return ID_EMPTY;
    if (roll < 70) return ID_INCLUSION;
    if (roll < 80) return id_t'($urandom);
    if (roll < 85) return ID_MAX;
    if (roll < 90) return ID_MIN;
    return id_t'($urandom_range(32767));
  endfunction

  function automatic id_t lean_pick(id_t g, int lean);
    return ($urandom_range(99) < lean) ? g : pick_grain();
  endfunction

  // Bias the ring towards one grain so that the count rules actually fire
  function automatic cell_item_t random_cell();
    cell_item_t c;
    id_t        g;
    int         lean;
    g    = pick_grain();
    lean = $urandom_range(100);
    c.center    = ($urandom_range(99) < 75) ? ID_EMPTY : pick_grain();
    c.north     = lean_pick(g, lean);
    c.east      = lean_pick(g, lean);
    c.south     = lean_pick(g, lean);
    c.west      = lean_pick(g, lean);
    c.northeast = lean_pick(g, lean);
    c.southeast = lean_pick(g, lean);
    c.southwest = lean_pick(g, lean);
    c.northwest = lean_pick(g, lean);
    c.pct = ($urandom_range(99) < 70) ? ggcr_pkg::PROB_W'($urandom_range(99))
                                      : ggcr_pkg::PROB_W'($urandom_range(127));
    return c;
  endfunction

  task automatic write_reg(input logic [ggcr_pkg::INDEX_W-1:0] idx,
                           input logic [WR_W-1:0] val);
    @(posedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    case (idx)
      ggcr_pkg::REG_MODE:   mode_r    = val[0];
      ggcr_pkg::REG_PROB:   prob_r    = val[ggcr_pkg::PROB_W-1:0];
      ggcr_pkg::REG_EXCL_A: excl_r[0] = val[ID_W-2:0];
      REG_EXCL_B:           excl_r[1] = val[ID_W-2:0];
      REG_EXCL_C:           excl_r[2] = val[ID_W-2:0];
      REG_EXCL_D:           excl_r[3] = val[ID_W-2:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(input logic [WR_W-1:0] mode, input logic [WR_W-1:0] prob,
                               input logic [WR_W-1:0] ea, input logic [WR_W-1:0] eb,
                               input logic [WR_W-1:0] ec, input logic [WR_W-1:0] ed);
    write_reg(ggcr_pkg::REG_MODE, mode);
    write_reg(ggcr_pkg::REG_PROB, prob);
    write_reg(ggcr_pkg::REG_EXCL_A, ea);
    write_reg(REG_EXCL_B, eb);
    write_reg(REG_EXCL_C, ec);
    write_reg(REG_EXCL_D, ed);
    @(posedge clk);
    wr_en <= 1'b0;
    settings_seen++;
  endtask

  task automatic drain();
    while (cells_to_send.size() != 0 || start || next_ids_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_random(input int idle, input int count);
    idle_pct = idle;
    repeat (count) queue_cell(random_cell());
    drain();
  endtask

  // Driver: predict on acceptance, then present the next transaction or go idle
  always @(posedge clk) begin : cell_driver
    cell_item_t   nxt;
    cell_result_t r;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        r = next_grain_id(cell_on_port);
        next_ids_due.insert(next_ids_due.size(), r);
        cells_sent++;
        if (r.grew) cells_grown++;
      end
      if (!start || !busy) begin
        if (cells_to_send.size() != 0 && $urandom_range(99) >= idle_pct) begin
          nxt          = cells_to_send.pop_front();
          cell_on_port = nxt;
          center_id      <= nxt.center;
          north_id       <= nxt.north;
          east_id        <= nxt.east;
          south_id       <= nxt.south;
          west_id        <= nxt.west;
          northeast_id   <= nxt.northeast;
          southeast_id   <= nxt.southeast;
          southwest_id   <= nxt.southwest;
          northwest_id   <= nxt.northwest;
          random_percent <= nxt.pct;
          start          <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_check
    cell_result_t want;
    if (!rst && done) begin
      if (next_ids_due.size() == 0) begin
        $error("unexpected result: new_id %0d grew %0b", $signed(new_id), grew);
        faults++;
      end else begin
        want = next_ids_due.pop_front();
        if (new_id !== want.new_id) begin
          $error("new_id: expected %0d, got %0d", want.new_id, $signed(new_id));
          faults++;
        end
        if (grew !== want.grew) begin
          $error("grew: expected %0b, got %0b", want.grew, grew);
          faults++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("grain_growth_cell_rule test failed");
      $finish;
    end
  end

  initial begin : stimulus
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset settings: simple growth, no barred ids
    queue_cell(neighbourhood(ID_MAX, 3, 3, 3, 3, 3, 3, 3, 3, 0));
    queue_cell(neighbourhood(ID_INCLUSION, 4, 4, 4, 4, 4, 4, 4, 4, 0));
    queue_cell(neighbourhood(ID_MIN, 1, 1, 1, 1, 1, 1, 1, 1, 0));
    queue_cell(neighbourhood(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    queue_cell(neighbourhood(0, -1, -1, -1, -1, 5, 5, 5, 5, 0));
    queue_cell(neighbourhood(0, 5, 5, 2, 2, 0, 0, 0, 0, 0));
    queue_cell(neighbourhood(0, -5, -5, 7, -1, 0, 0, 0, 0, 0));
    queue_cell(neighbourhood(0, ID_MIN, 3, 0, 0, 0, 0, 0, 0, 0));
    queue_cell(neighbourhood(0, ID_MAX, ID_MAX, ID_MAX, ID_MAX,
                             ID_MIN, ID_MIN, ID_MIN, ID_MIN, 127));
    queue_cell(neighbourhood(0, 0, 0, 0, 8, 9, 9, 9, 9, 99));
    run_random(0, 180);

    // masked writes, full-width barred id, spare indexes must be ignored
    load_settings(15'h7FFE, 15'h7FE4, 2, 5, 32767, 0);
    write_reg(REG_SPARE_LO, '1);
    write_reg(REG_SPARE_HI, '1);
    @(posedge clk);
    wr_en <= 1'b0;
    run_random(75, 180);

    // curvature mode, each rule in turn
    load_settings(MODE_CURVE, 40, 9, 0, 0, 0);
    idle_pct = 0;
    queue_cell(neighbourhood(0, 1, 1, 1, 1, 1, 1, 1, 1, 0));
    queue_cell(neighbourhood(0, 4, 4, 0, 0, 4, 4, 4, 0, 99));
    queue_cell(neighbourhood(0, 9, 9, 9, 9, 9, 0, 0, 0, 0));
    queue_cell(neighbourhood(0, 6, 6, 6, 8, 0, 0, 0, 0, 99));
    queue_cell(neighbourhood(0, 6, 6, 6, 9, 9, 9, 9, -1, 0));
    queue_cell(neighbourhood(0, 12, 0, 0, 0, 11, 11, 11, 0, 99));
    queue_cell(neighbourhood(0, 2, 0, 0, 0, 0, 0, 0, 0, 39));
    queue_cell(neighbourhood(0, 2, 0, 0, 0, 0, 0, 0, 0, 40));
    queue_cell(neighbourhood(0, 2, 0, 0, 0, 0, 0, 0, 0, 127));
    queue_cell(neighbourhood(0, 7, 7, 7, 7, 0, 0, 0, 0, 99));
    queue_cell(neighbourhood(0, 9, 9, 10, 10, 0, 0, 0, 0, 0));
    queue_cell(neighbourhood(5, 6, 6, 6, 6, 6, 6, 6, 6, 0));
    run_random(0, 180);

    load_settings(MODE_CURVE, 0, 1, 3, 32767, 6);
    run_random(30, 180);

    load_settings(MODE_CURVE, 15'h7FFF, 0, 0, 0, 0);
    run_random(75, 180);

    load_settings(MODE_CURVE, 100, 4, 4, 0, 2);
    run_random(30, 180);

    load_settings(ggcr_pkg::MODE_SIMPLE, 0, 1, 2, 3, 4);
    run_random(0, 180);

    $display("Checked %0d cells under %0d register settings: both growth modes, idle 0/30/75%%",
             cells_sent, settings_seen);
    $display("%0d empty cells grew, %0d mismatches", cells_grown, faults);
    if (faults == 0) begin
      $display("grain_growth_cell_rule test passed");
    end else begin
      $display("grain_growth_cell_rule test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
